FILE: rtl/kclc_pkg.sv
`timescale 1ns / 1ps

package kclc_pkg;

   // Command codes carried in the cmd field.
   localparam logic [1:0] CMD_KEY    = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_SENSOR = 2'd2;

   // Key codes above the digits.
   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_CONFIRM    = 4'd10;
   localparam logic [3:0] KEY_SETTINGS   = 4'd11;
   localparam logic [3:0] KEY_EXIT       = 4'd12;
   localparam logic [3:0] KEY_FACTORY    = 4'd13;

   localparam logic [3:0] DIGIT_BLANK = 4'd10;
   localparam int         SHOWN_DIGITS = 6;

   // Configuration register indexes.
   localparam int        CSR_INDEX_W = 3;
   localparam int        CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_HOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUZZER_HOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FAIL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_THRESH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAY_START   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAY_END     = 3'd5;

   typedef struct packed {
      logic [15:0] relay_hold_ms;
      logic [15:0] buzzer_hold_ms;
      logic [2:0]  max_failures;
      logic [9:0]  near_threshold_cm;
      logic [4:0]  day_start_hour;
      logic [4:0]  day_end_hour;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] key;
      logic [4:0] hour;
      logic [9:0] distance_cm;
   } req_payload_type;

   typedef struct packed {
      logic        relay_on;
      logic        buzzer_on;
      logic        in_settings;
      logic        new_code_armed;
      logic [2:0]  digits_entered;
      logic [23:0] entered_code;
      logic        code_saved;
      logic [23:0] stored_code;
   } rsp_payload_type;

endpackage

FILE: rtl/kclc_csr_regs.sv
`timescale 1ns / 1ps

module kclc_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [kclc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kclc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output kclc_pkg::cfg_type                cfg
);
   import kclc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RELAY_HOLD:  cfg_in.relay_hold_ms     = csr_wdata;
            CSR_BUZZER_HOLD: cfg_in.buzzer_hold_ms    = csr_wdata;
            CSR_MAX_FAIL:    cfg_in.max_failures      = csr_wdata[2:0];
            CSR_NEAR_THRESH: cfg_in.near_threshold_cm = csr_wdata[9:0];
            CSR_DAY_START:   cfg_in.day_start_hour    = csr_wdata[4:0];
            CSR_DAY_END:     cfg_in.day_end_hour      = csr_wdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relay_hold_ms     <= 16'd5000;
         cfg_ff.buzzer_hold_ms    <= 16'd3000;
         cfg_ff.max_failures      <= 3'd3;
         cfg_ff.near_threshold_cm <= 10'd30;
         cfg_ff.day_start_hour    <= 5'd7;
         cfg_ff.day_end_hour      <= 5'd22;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/kclc_lock_state.sv
`timescale 1ns / 1ps

module kclc_lock_state #(
   parameter int CODE_LEN = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  kclc_pkg::req_payload_type req,
   input  kclc_pkg::cfg_type         cfg,
   output kclc_pkg::rsp_payload_type result
);
   import kclc_pkg::*;

   localparam int CntW = $clog2(CODE_LEN + 1);

   logic [3:0]      code_ff [CODE_LEN];
   logic [3:0]      code_in [CODE_LEN];
   logic [3:0]      entry_ff [CODE_LEN];
   logic [3:0]      entry_in [CODE_LEN];
   logic [3:0]      factory_digits [CODE_LEN];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [2:0]      fail_ff, fail_in, fail_inc;
   logic            settings_ff, settings_in;
   logic            armed_ff, armed_in;
   logic            relay_ff, relay_in;
   logic            buzzer_ff, buzzer_in;
   logic [15:0]     relay_tmr_ff, relay_tmr_in, relay_tmr_inc;
   logic [15:0]     buzzer_tmr_ff, buzzer_tmr_in, buzzer_tmr_inc;
   logic            saved;
   logic            code_match;
   logic            is_digit;
   logic [7:0]      cnt_wide;
   logic [3:0]      entry_shown [SHOWN_DIGITS];
   logic [3:0]      code_shown [SHOWN_DIGITS];

   always_comb begin
      for (int k = 0; k < CODE_LEN; k++) begin
         factory_digits[k] = 4'((CODE_LEN - k) % 10);
      end
   end

   always_comb begin
      code_match = 1'b1;
      for (int k = 0; k < CODE_LEN; k++) begin
         if (entry_ff[k] != code_ff[k]) begin
            code_match = 1'b0;
         end
      end
   end

   assign is_digit       = (req.key <= KEY_LAST_DIGIT);
   assign fail_inc       = fail_ff + 3'd1;
   assign relay_tmr_inc  = relay_tmr_ff + 16'd1;
   assign buzzer_tmr_inc = buzzer_tmr_ff + 16'd1;

   always_comb begin
      code_in       = code_ff;
      entry_in      = entry_ff;
      cnt_in        = cnt_ff;
      fail_in       = fail_ff;
      settings_in   = settings_ff;
      armed_in      = armed_ff;
      relay_in      = relay_ff;
      buzzer_in     = buzzer_ff;
      relay_tmr_in  = relay_tmr_ff;
      buzzer_tmr_in = buzzer_tmr_ff;
      saved         = 1'b0;

      case (req.cmd)
         CMD_KEY: begin
            if (is_digit) begin
               if (cnt_ff < CntW'(CODE_LEN)) begin
                  for (int k = 0; k < CODE_LEN; k++) begin
                     if (cnt_ff == CntW'(k)) begin
                        entry_in[k] = req.key;
                     end
                  end
                  cnt_in = cnt_ff + CntW'(1);
               end
            end else begin
               case (req.key)
                  KEY_CONFIRM: begin
                     if (settings_ff && armed_ff) begin
                        code_in     = entry_ff;
                        settings_in = 1'b0;
                        armed_in    = 1'b0;
                        saved       = 1'b1;
                     end else if (code_match) begin
                        fail_in = 3'd0;
                        if (settings_ff) begin
                           armed_in = 1'b1;
                        end else begin
                           relay_in = 1'b1;
                        end
                     end else if (fail_inc >= cfg.max_failures) begin
                        // A limit of zero behaves like a limit of one.
                        fail_in   = 3'd0;
                        buzzer_in = 1'b1;
                     end else begin
                        fail_in = fail_inc;
                     end
                     for (int k = 0; k < CODE_LEN; k++) entry_in[k] = DIGIT_BLANK;
                     cnt_in = '0;
                  end
                  KEY_SETTINGS: begin
                     settings_in = 1'b1;
                     for (int k = 0; k < CODE_LEN; k++) entry_in[k] = DIGIT_BLANK;
                     cnt_in = '0;
                  end
                  KEY_EXIT: begin
                     if (settings_ff) begin
                        settings_in = 1'b0;
                        armed_in    = 1'b0;
                        for (int k = 0; k < CODE_LEN; k++) entry_in[k] = DIGIT_BLANK;
                        cnt_in = '0;
                     end
                  end
                  KEY_FACTORY: begin
                     code_in = factory_digits;
                     saved   = 1'b1;
                  end
                  default: begin
                     saved = 1'b0;
                  end
               endcase
            end
         end
         CMD_TICK: begin
            // A running timer that reaches its hold time switches its device off.
            if (relay_ff) begin
               if (relay_tmr_inc >= cfg.relay_hold_ms) begin
                  relay_tmr_in = 16'd0;
                  relay_in     = 1'b0;
               end else begin
                  relay_tmr_in = relay_tmr_inc;
               end
            end else begin
               relay_tmr_in = 16'd0;
            end
            if (buzzer_ff) begin
               if (buzzer_tmr_inc >= cfg.buzzer_hold_ms) begin
                  buzzer_tmr_in = 16'd0;
                  buzzer_in     = 1'b0;
               end else begin
                  buzzer_tmr_in = buzzer_tmr_inc;
               end
            end else begin
               buzzer_tmr_in = 16'd0;
            end
         end
         CMD_SENSOR: begin
            if ((req.hour >= cfg.day_start_hour) && (req.hour < cfg.day_end_hour) &&
                (req.distance_cm < cfg.near_threshold_cm)) begin
               relay_in = 1'b1;
            end
         end
         default: begin
            saved = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= factory_digits;
         for (int k = 0; k < CODE_LEN; k++) entry_ff[k] <= DIGIT_BLANK;
         cnt_ff        <= '0;
         fail_ff       <= 3'd0;
         settings_ff   <= 1'b0;
         armed_ff      <= 1'b0;
         relay_ff      <= 1'b0;
         buzzer_ff     <= 1'b0;
         relay_tmr_ff  <= 16'd0;
         buzzer_tmr_ff <= 16'd0;
      end else if (step) begin
         code_ff       <= code_in;
         entry_ff      <= entry_in;
         cnt_ff        <= cnt_in;
         fail_ff       <= fail_in;
         settings_ff   <= settings_in;
         armed_ff      <= armed_in;
         relay_ff      <= relay_in;
         buzzer_ff     <= buzzer_in;
         relay_tmr_ff  <= relay_tmr_in;
         buzzer_tmr_ff <= buzzer_tmr_in;
      end
   end

   // Positions past the code length show as blank in the entry and zero in the code.
   for (genvar k = 0; k < SHOWN_DIGITS; k++) begin : g_shown
      if (k < CODE_LEN) begin : g_real
         assign entry_shown[k] = entry_in[k];
         assign code_shown[k]  = code_in[k];
      end else begin : g_pad
         assign entry_shown[k] = DIGIT_BLANK;
         assign code_shown[k]  = 4'd0;
      end
   end

   assign cnt_wide = 8'(cnt_in);

   always_comb begin
      result.relay_on       = relay_in;
      result.buzzer_on      = buzzer_in;
      result.in_settings    = settings_in;
      result.new_code_armed = armed_in;
      result.digits_entered = (cnt_wide > 8'd7) ? 3'd7 : cnt_wide[2:0];
      result.code_saved     = saved;
      for (int k = 0; k < SHOWN_DIGITS; k++) begin
         result.entered_code[23-4*k -: 4] = entry_shown[k];
         result.stored_code[23-4*k -: 4]  = code_shown[k];
      end
   end

   // The armed flag only lives inside the settings menu.
   a_armed_in_settings: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> settings_ff)
      else $error("armed flag set outside settings mode");

   // An idle device keeps its timer at zero, so a new trigger starts a full hold.
   a_relay_timer_idle: assert property (@(posedge clock) disable iff (reset)
      !relay_ff |-> (relay_tmr_ff == 16'd0))
      else $error("relay timer running while relay is off");

   a_buzzer_timer_idle: assert property (@(posedge clock) disable iff (reset)
      !buzzer_ff |-> (buzzer_tmr_ff == 16'd0))
      else $error("buzzer timer running while buzzer is off");

   a_tick_keeps_entry: assert property (@(posedge clock) disable iff (reset)
      (step && (req.cmd == CMD_TICK)) |=> $stable(cnt_ff) && $stable(settings_ff))
      else $error("tick beat changed the entry or the mode");

endmodule

FILE: rtl/keypad_code_lock_controller_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// req_*     in         cmd, key, hour, distance_cm
// rsp_*     out        relay, buzzer, menu flags, entry and stored code, save pulse
// csr_*     in         register write: index, 16-bit data, no read-back
//
// A beat is decided as it leaves the input register, by a single pass of the lock logic
// (one parallel code compare, timer add and compare). One beat per cycle is sustained
// while rsp_ready is high; a beat passes the input register and then the result
// register to rsp_valid. Synchronous active-high reset restores the factory code,
// the register defaults and clears both stages. A stalled result holds in its register
// while the input register keeps one more beat; req_ready drops only when both are full.

module keypad_code_lock_controller_core #(
   parameter int CODE_LEN = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  kclc_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output kclc_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_we,
   input  logic [kclc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kclc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kclc_pkg::*;

   cfg_type         cfg;
   req_payload_type in_data_ff;
   logic            in_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type next_result;
   logic            rsp_valid_ff;
   logic            advance;

   // A beat moves from the input register into the result register when the
   // result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= next_result;
      end
   end

   kclc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kclc_lock_state #(
      .CODE_LEN (CODE_LEN)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .req    (in_data_ff),
      .cfg    (cfg),
      .result (next_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
